// ===== hw/rtl/lfsa_pkg.sv =====
// ---------------------------------------------------------------------------
// Lowest free slot allocator package
// Field widths, configuration register codes and the controller command type.
// ---------------------------------------------------------------------------
package lfsa_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned SLOT_IDX_W = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GUEST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 1'd1;

  localparam logic [ID_W-1:0]    TARGET_GUEST_RST = 16'd0;
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST   = 7'd64;

  // command from the controller to the datapath
  typedef struct packed {
    logic clear_wr;    // write a free entry at the sweep address
    logic rd_en;       // read the entry at the sweep address
    logic load_guest;  // capture an accepted guest, restart the search
    logic out_load;    // move the finished result into the output register
  } lfsa_cmd_t;

endpackage

// ===== hw/rtl/lfsa_guest_if.sv =====
// ---------------------------------------------------------------------------
// Guest channel
// Valid/ready channel carrying one guest per beat.
// ---------------------------------------------------------------------------
interface lfsa_guest_if;

  logic                              valid;
  logic                              ready;
  logic [lfsa_pkg::TIME_W-1:0]       arrival_time;
  logic [lfsa_pkg::TIME_W-1:0]       leave_time;
  logic [lfsa_pkg::ID_W-1:0]         guest_id;

  modport source (output valid, arrival_time, leave_time, guest_id, input ready);
  modport sink   (input valid, arrival_time, leave_time, guest_id, output ready);

endinterface

// ===== hw/rtl/lfsa_result_if.sv =====
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one slot assignment per beat.
// ---------------------------------------------------------------------------
interface lfsa_result_if;

  logic                              valid;
  logic                              ready;
  logic [lfsa_pkg::SLOT_IDX_W-1:0]   slot_index;
  logic                              no_free_slot;
  logic                              is_target;

  modport source (output valid, slot_index, no_free_slot, is_target, input ready);
  modport sink   (input valid, slot_index, no_free_slot, is_target, output ready);

endinterface

// ===== hw/rtl/lfsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Allocator controller
// Sequences the clearing pass, the per-guest slot sweep and the result beat.
// ---------------------------------------------------------------------------
module lfsa_ctrl #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lfsa_pkg::lfsa_cmd_t cmd_o,
  output logic [IW-1:0]       slot_addr_o
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [IW-1:0] LAST_ADDR = IW'(SLOTS - 1);

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          drain_q, drain_d;  // last read issued, its entry still in flight
  logic          out_valid_q, out_valid_d;
  logic          accept;
  logic          out_free;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_guest = 1'b1;
          cnt_d            = '0;
          drain_d          = 1'b0;
          state_d          = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (drain_q) begin
          // the last entry is evaluated this cycle
          drain_d = 1'b0;
          state_d = ST_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == LAST_ADDR) begin
            cnt_d   = '0;
            drain_d = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_addr_o = cnt_q;

endmodule

// ===== hw/rtl/lfsa_datapath.sv =====
// ---------------------------------------------------------------------------
// Allocator datapath
// Slot table memory, release check, lowest free slot pick and result register.
// ---------------------------------------------------------------------------
module lfsa_datapath #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfsa_pkg::lfsa_cmd_t                 cmd_i,
  input  logic [IW-1:0]                       slot_addr_i,
  input  logic                                cfg_we_i,
  input  logic [lfsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfsa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [lfsa_pkg::TIME_W-1:0]         arrival_time_i,
  input  logic [lfsa_pkg::TIME_W-1:0]         leave_time_i,
  input  logic [lfsa_pkg::ID_W-1:0]           guest_id_i,
  output logic [lfsa_pkg::SLOT_IDX_W-1:0]     slot_index_o,
  output logic                                no_free_slot_o,
  output logic                                is_target_o
);

  localparam int unsigned TW   = lfsa_pkg::TIME_W;
  localparam int unsigned CMPW = (IW > lfsa_pkg::COUNT_W) ? IW : lfsa_pkg::COUNT_W;

  // entry layout: busy flag above the release time
  logic [TW:0] slot_mem_q [SLOTS];
  logic [TW:0] rd_data_q;
  logic        rd_vld_q;
  logic [IW-1:0] rd_addr_q;

  logic [lfsa_pkg::ID_W-1:0]    target_guest_q;
  logic [lfsa_pkg::COUNT_W-1:0] slot_count_q;

  logic [TW-1:0]               arrival_q;
  logic [TW-1:0]               leave_q;
  logic [lfsa_pkg::ID_W-1:0]   id_q;
  logic                        found_q, found_d;
  logic [IW-1:0]               chosen_q, chosen_d;

  logic [lfsa_pkg::SLOT_IDX_W-1:0] slot_index_q;
  logic                            no_free_slot_q;
  logic                            is_target_q;

  logic          ent_busy;
  logic [TW-1:0] ent_release;
  logic          ent_still_busy;
  logic          ent_freed;
  logic          in_range;
  logic          take;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [TW:0]   mem_wd;
  logic [CMPW-1:0] chosen_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_guest_q <= lfsa_pkg::TARGET_GUEST_RST;
      slot_count_q   <= lfsa_pkg::SLOT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfsa_pkg::CFG_TARGET_GUEST: target_guest_q <= cfg_data_i;
        lfsa_pkg::CFG_SLOT_COUNT:   slot_count_q   <= cfg_data_i[lfsa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // evaluate the entry read in the previous cycle
  assign ent_busy       = rd_data_q[TW];
  assign ent_release    = rd_data_q[TW-1:0];
  assign ent_still_busy = ent_busy && (ent_release > arrival_q);
  assign ent_freed      = ent_busy && !ent_still_busy;
  assign in_range       = CMPW'(rd_addr_q) < CMPW'(slot_count_q);
  assign take           = rd_vld_q && !ent_still_busy && in_range && !found_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_addr_q;
    mem_wd = {1'b0, ent_release};
    if (cmd_i.clear_wr) begin
      mem_we = 1'b1;
      mem_wa = slot_addr_i;
      mem_wd = '0;
    end else if (take) begin
      mem_we = 1'b1;
      mem_wd = {1'b1, leave_q};
    end else if (rd_vld_q && ent_freed) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= slot_mem_q[slot_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  always_comb begin
    found_d  = found_q;
    chosen_d = chosen_q;
    if (cmd_i.load_guest) begin
      found_d  = 1'b0;
      chosen_d = '0;
    end else if (take) begin
      found_d  = 1'b1;
      chosen_d = rd_addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= slot_addr_i;
    chosen_q  <= chosen_d;
    if (cmd_i.load_guest) begin
      arrival_q <= arrival_time_i;
      leave_q   <= leave_time_i;
      id_q      <= guest_id_i;
    end
  end

  assign chosen_ext = CMPW'(chosen_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot_index_q   <= found_q ? chosen_ext[lfsa_pkg::SLOT_IDX_W-1:0] : '0;
      no_free_slot_q <= !found_q;
      is_target_q    <= (id_q == target_guest_q);
    end
  end

  assign slot_index_o   = slot_index_q;
  assign no_free_slot_o = no_free_slot_q;
  assign is_target_o    = is_target_q;

endmodule

// ===== hw/rtl/lowest_free_slot_allocator.sv =====
// ---------------------------------------------------------------------------
// Lowest free slot allocator
// Assigns each arriving guest the lowest-numbered free slot.
// ---------------------------------------------------------------------------
// Each guest beat (arrival, leave, id) yields one result beat. While the guest
// is handled, one pass walks the slot table from slot 0 to SLOTS-1: a busy
// slot whose release time is at or before the arrival is freed, and the first
// free slot below slot_count is taken and gets the guest's leave time. When no
// slot is free, no_free_slot is set and slot_index is 0. is_target marks a
// guest whose id matches target_guest. Guests must come in nondecreasing
// arrival order; no check is made. From accept to the next accept, the pass
// reads one table entry per cycle from a single-read memory, then the last
// entry is evaluated, the result register is loaded once it is free, and the
// block goes idle, where the next guest is accepted. The result register
// holds a finished beat while the next guest is taken. After reset, a
// clearing pass marks every slot free; no guest is accepted during it. Write
// configuration only while the block is idle.
// ---------------------------------------------------------------------------
module lowest_free_slot_allocator #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lfsa_guest_if.sink                        guest_i,
  lfsa_result_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [lfsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfsa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  lfsa_pkg::lfsa_cmd_t cmd;
  logic [IW-1:0]       slot_addr;

  // sequence clearing, sweep and result beat
  lfsa_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (guest_i.valid),
    .in_ready_o  (guest_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .slot_addr_o (slot_addr)
  );

  // hold the slot table, pick the slot, drive the result payload
  lfsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .slot_addr_i    (slot_addr),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .arrival_time_i (guest_i.arrival_time),
    .leave_time_i   (guest_i.leave_time),
    .guest_id_i     (guest_i.guest_id),
    .slot_index_o   (result_o.slot_index),
    .no_free_slot_o (result_o.no_free_slot),
    .is_target_o    (result_o.is_target)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lowest free slot allocator testbench
// Drives guests with random valid/ready gaps and checks every slot grant
// against a behavioral occupancy model held in a small scoreboard class.
// ---------------------------------------------------------------------------

typedef struct packed {
  logic [lfsa_pkg::SLOT_IDX_W-1:0] slot_index;
  logic                            no_free_slot;
  logic                            is_target;
} slot_grant_t;

class slot_book #(int SLOTS = 64);

  bit                              busy [SLOTS];
  logic [lfsa_pkg::TIME_W-1:0]     free_at [SLOTS];
  logic [lfsa_pkg::ID_W-1:0]       target;
  logic [lfsa_pkg::COUNT_W-1:0]    count;
  slot_grant_t                     pending_grants [$];
  int                              errors;

  function new();
    target = lfsa_pkg::TARGET_GUEST_RST;
    count  = lfsa_pkg::SLOT_COUNT_RST;
    foreach (busy[i]) busy[i] = 1'b0;
    errors = 0;
  endfunction

  function void write_reg(logic [lfsa_pkg::CFG_IDX_W-1:0] idx,
                          logic [lfsa_pkg::CFG_DATA_W-1:0] data);
    if (idx == lfsa_pkg::CFG_TARGET_GUEST) begin
      target = data[lfsa_pkg::ID_W-1:0];
    end else if (idx == lfsa_pkg::CFG_SLOT_COUNT) begin
      count = data[lfsa_pkg::COUNT_W-1:0];
    end
  endfunction

  // Free expired slots, take the lowest free one below the count.
  function void seat_guest(logic [lfsa_pkg::TIME_W-1:0] arrival,
                           logic [lfsa_pkg::TIME_W-1:0] leave,
                           logic [lfsa_pkg::ID_W-1:0]   id);
    int          in_use;
    int          chosen;
    bit          found;
    slot_grant_t grant;
    in_use = (count > SLOTS) ? SLOTS : int'(count);
    for (int i = 0; i < SLOTS; i++) begin
      if (busy[i] && free_at[i] <= arrival) busy[i] = 1'b0;
    end
    found  = 1'b0;
    chosen = 0;
    for (int i = 0; i < in_use && !found; i++) begin
      if (!busy[i]) begin
        chosen = i;
        found  = 1'b1;
      end
    end
    if (found) begin
      busy[chosen]    = 1'b1;
      free_at[chosen] = leave;
    end
    grant.slot_index   = found ? lfsa_pkg::SLOT_IDX_W'(chosen) : '0;
    grant.no_free_slot = !found;
    grant.is_target    = (id == target);
    pending_grants = {pending_grants, grant};
  endfunction

  function void check_grant(slot_grant_t got);
    slot_grant_t want;
    if (pending_grants.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected grant: slot %0d full %0b target %0b",
                 got.slot_index, got.no_free_slot, got.is_target);
      return;
    end
    want = pending_grants.pop_front();
    if (got.slot_index !== want.slot_index || got.no_free_slot !== want.no_free_slot ||
        got.is_target !== want.is_target) begin
      errors++;
      if (errors <= 10)
        $display("grant mismatch: expected slot %0d full %0b target %0b, got slot %0d full %0b target %0b",
                 want.slot_index, want.no_free_slot, want.is_target,
                 got.slot_index, got.no_free_slot, got.is_target);
    end
  endfunction

  function int pending();
    return pending_grants.size();
  endfunction

  function void count_leftovers();
    if (pending_grants.size() != 0) begin
      $display("%0d grants never arrived", pending_grants.size());
      errors += pending_grants.size();
    end
  endfunction

endclass

module tb;

  localparam int SLOTS       = 64;
  localparam int STALL_LIMIT = 4000;  // cycles without any beat before giving up
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 175;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [lfsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [lfsa_pkg::CFG_DATA_W-1:0] cfg_data_i;

  lfsa_guest_if  guest_bus ();
  lfsa_result_if result_bus ();

  slot_book #(SLOTS) book;

  bit no_idle;        // drop all random gaps on both sides
  bit hold_results;   // ask the receiver for one long hold-off
  int stall_cycles;

  lowest_free_slot_allocator #(.SLOTS(SLOTS)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .guest_i    (guest_bus),
    .result_o   (result_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: toggle ready at the falling edge, idle about a quarter of the
  // time, and honor one long hold-off counted here.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_results = 1'b0;
      end else begin
        result_bus.ready <= no_idle || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // Monitor: check each result beat at the rising edge and watch for a hang.
  always @(posedge clk_i) begin
    slot_grant_t got;
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        got.slot_index   = result_bus.slot_index;
        got.no_free_slot = result_bus.no_free_slot;
        got.is_target    = result_bus.is_target;
        book.check_grant(got);
      end
      if ((guest_bus.valid && guest_bus.ready) || (result_bus.valid && result_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("lowest_free_slot_allocator regression: fail");
        $finish;
      end
    end
  end

  // Offer one guest beat, with a random gap first; return at the falling
  // edge after acceptance so valid stays high into the next call.
  task automatic drive_guest(input logic [lfsa_pkg::TIME_W-1:0] arrival,
                             input logic [lfsa_pkg::TIME_W-1:0] leave,
                             input logic [lfsa_pkg::ID_W-1:0]   id);
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      guest_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    guest_bus.valid        <= 1'b1;
    guest_bus.arrival_time <= arrival;
    guest_bus.leave_time   <= leave;
    guest_bus.guest_id     <= id;
    @(posedge clk_i);
    while (!guest_bus.ready) @(posedge clk_i);
    book.seat_guest(arrival, leave, id);
    @(negedge clk_i);
  endtask

  // Drop valid and hold the sender until every predicted grant has come back.
  task automatic wait_drain();
    guest_bus.valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
  endtask

  // Called at a falling edge while the block is idle.
  task automatic cfg_write(input logic [lfsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfsa_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    book.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    // reset settings: target 0, all 64 slots; zero-length stay frees at once
    drive_guest(32'd0, 32'd0, 16'h0000);
    drive_guest(32'd0, 32'd5, 16'h0001);
    wait_drain();
    cfg_write(lfsa_pkg::CFG_TARGET_GUEST, 16'hFFFF);
    cfg_write(lfsa_pkg::CFG_SLOT_COUNT, 16'd2);
    // fill both slots, then hit the all-busy case, then free by arrival
    drive_guest(32'd1, 32'd100, 16'hFFFF);
    drive_guest(32'd2, 32'hFFFF_FFFF, 16'h8000);
    drive_guest(32'd5, 32'hFFFF_FFFF, 16'h7FFF);
    drive_guest(32'd100, 32'd200, 16'hFFFF);
    drive_guest(32'd150, 32'd10, 16'h0000);
    wait_drain();
    // no slot in use at all: every guest is refused, target still flagged
    cfg_write(lfsa_pkg::CFG_SLOT_COUNT, 16'd0);
    drive_guest(32'd300, 32'd400, 16'h1234);
    drive_guest(32'd300, 32'd400, 16'hFFFF);
    wait_drain();
    // count beyond the table saturates
    cfg_write(lfsa_pkg::CFG_SLOT_COUNT, 16'd127);
    drive_guest(32'd301, 32'd500, 16'hAAAA);
    drive_guest(32'd302, 32'd600, 16'h5555);
    drive_guest(32'd303, 32'd700, 16'h0001);
    wait_drain();
    // lower the count while upper slots are busy; they still get freed
    cfg_write(lfsa_pkg::CFG_SLOT_COUNT, 16'd1);
    drive_guest(32'd350, 32'd360, 16'h0002);
    drive_guest(32'd650, 32'd660, 16'h0003);
    wait_drain();
    cfg_write(lfsa_pkg::CFG_SLOT_COUNT, 16'd65);
    drive_guest(32'd651, 32'd0, 16'h0004);
    // arrival out of order: the freeing rule still uses it as given
    drive_guest(32'd40, 32'd41, 16'h0005);
    // maximum arrival frees everything
    drive_guest(32'hFFFF_FFFF, 32'd0, 16'hFFFF);
    drive_guest(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
    drive_guest(32'hFFFF_FFFF, 32'd0, 16'h0F0F);
  endtask

  // One random phase: mostly ordered guests with random stays, some noise.
  task automatic run_phase(input logic [lfsa_pkg::ID_W-1:0]    target,
                           input logic [lfsa_pkg::COUNT_W-1:0] count,
                           input logic [lfsa_pkg::TIME_W-1:0]  base,
                           input bit                           long_hold);
    logic [lfsa_pkg::TIME_W-1:0] arrival;
    logic [lfsa_pkg::TIME_W-1:0] leave;
    logic [lfsa_pkg::ID_W-1:0]   id;
    int                          pick;
    wait_drain();
    cfg_write(lfsa_pkg::CFG_TARGET_GUEST, target);
    cfg_write(lfsa_pkg::CFG_SLOT_COUNT,
              {{(lfsa_pkg::CFG_DATA_W-lfsa_pkg::COUNT_W){1'b0}}, count});
    // flush slots left over from earlier phases
    drive_guest(32'hFFFF_FFFF, 32'd0, lfsa_pkg::ID_W'($urandom));
    arrival = base;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 4 && long_hold) hold_results = 1'b1;
      if (i == PHASE_ITEMS / 2) wait_drain();
      id   = ($urandom_range(0, 5) == 0) ? target : lfsa_pkg::ID_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // broken ordering: arbitrary arrival and leave
        drive_guest($urandom, $urandom, id);
      end else begin
        arrival += $urandom_range(0, 12);
        pick = $urandom_range(0, 19);
        if (pick < 6)       leave = arrival + $urandom_range(0, 4);
        else if (pick < 12) leave = arrival + $urandom_range(0, 64);
        else if (pick < 19) leave = arrival + $urandom_range(0, 1024);
        else                leave = arrival + $urandom;
        drive_guest(arrival, leave, id);
      end
    end
  endtask

  initial begin
    logic [lfsa_pkg::COUNT_W-1:0] counts [PHASES];
    logic [lfsa_pkg::TIME_W-1:0]  base;
    logic [lfsa_pkg::ID_W-1:0]    target;
    counts = '{7'd8, 7'd1, 7'd64, 7'd3, 7'd127, 7'd0, 7'd16, 7'd2, 7'd65, 7'd5};
    book = new();
    no_idle      = 1'b0;
    hold_results = 1'b0;
    stall_cycles = 0;
    guest_bus.valid        = 1'b0;
    guest_bus.arrival_time = '0;
    guest_bus.leave_time   = '0;
    guest_bus.guest_id     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = lfsa_pkg::CFG_TARGET_GUEST;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    // Advance the time base across the whole 32-bit range, phase by phase;
    // the last phase starts just below the top so arrivals wrap.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) base = 32'hFFFF_FC00;
      else                  base = ph * 32'h1999_9999 + $urandom_range(0, 32'h00FF_FFFF);
      if (ph == 0)      target = 16'h0000;
      else if (ph == 1) target = 16'hFFFF;
      else              target = lfsa_pkg::ID_W'($urandom);
      no_idle = (ph == 4);
      run_phase(target, counts[ph], base, ph == 2);
    end
    no_idle = 1'b0;

    // Drain, then let the block settle for one more pass.
    wait_drain();
    repeat (SLOTS + 8) @(posedge clk_i);
    book.count_leftovers();
    if (book.errors == 0) begin
      $display("lowest_free_slot_allocator regression: pass");
    end else begin
      $display("lowest_free_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== lowest_free_slot_allocator.f =====
hw/rtl/lfsa_pkg.sv
hw/rtl/lfsa_guest_if.sv
hw/rtl/lfsa_result_if.sv
hw/rtl/lfsa_ctrl.sv
hw/rtl/lfsa_datapath.sv
hw/rtl/lowest_free_slot_allocator.sv
test/tb.sv
